@@ rtl/core/itrs_pkg.sv @@
// Shared types, constants and helpers for the integer to radix symbol block.
// Used by the controller, the datapath and the top level; depends on nothing.
package itrs_pkg;

  localparam int MAX_SYMBOLS  = 16;
  localparam int NUMBER_WIDTH = 32;

  localparam int SYM_W     = 8;
  localparam int RADIX_W   = 5;
  localparam int ALPHA_W   = 64;
  localparam int SYM_IDX_W = 4;
  localparam int CFG_IDX_W = 2;
  localparam int DIV_BITS  = 4;

  localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;
  localparam logic [SYM_W-1:0] SYM_NUL   = 8'h00;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RADIX   = 2'd0,
    REG_ALPHA_LO = 2'd1,
    REG_ALPHA_HI = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_MINUS,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic chk_next;
    logic div_init;
    logic div_step;
    logic emit_minus;
    logic emit_digit;
  } cmd_t;

  typedef struct packed {
    logic radix_ok;
    logic sym_bad;
    logic chk_last;
    logic div_last;
    logic quo_zero;
    logic neg;
    logic emit_last;
    logic out_free;
  } sts_t;

  function automatic logic [SYM_W-1:0] sym_at(input logic [ALPHA_W-1:0] lo,
                                              input logic [ALPHA_W-1:0] hi,
                                              input logic [SYM_IDX_W-1:0] d);
    logic [2*ALPHA_W-1:0] w;
    w = {hi, lo};
    return w[{d, 3'b000} +: SYM_W];
  endfunction

endpackage

@@ rtl/core/itrs_ctrl.sv @@
// Sequencer for the radix symbol block: base check, digit division, emission.
// Depends on itrs_pkg for the state, command and status types.
module itrs_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  itrs_pkg::sts_t  sts,
  output itrs_pkg::cmd_t  cmd
);

  itrs_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= itrs_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      itrs_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = itrs_pkg::ST_CHECK;
        end
      end
      itrs_pkg::ST_CHECK: begin
        if (!sts.radix_ok || sts.sym_bad) begin
          state_nxt = itrs_pkg::ST_IDLE;
        end else if (sts.chk_last) begin
          cmd.div_init = 1'b1;
          state_nxt    = itrs_pkg::ST_DIV;
        end else begin
          cmd.chk_next = 1'b1;
        end
      end
      itrs_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last && sts.quo_zero) begin
          state_nxt = sts.neg ? itrs_pkg::ST_MINUS : itrs_pkg::ST_EMIT;
        end
      end
      itrs_pkg::ST_MINUS: begin
        if (sts.out_free) begin
          cmd.emit_minus = 1'b1;
          state_nxt      = itrs_pkg::ST_EMIT;
        end
      end
      itrs_pkg::ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_digit = 1'b1;
          if (sts.emit_last) begin
            state_nxt = itrs_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = itrs_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/core/itrs_dp.sv @@
// Datapath: configuration registers, base checker, 4-bit-per-cycle divider,
// digit stack and output register. Depends on itrs_pkg.
module itrs_dp #(
  parameter int NUMBER_WIDTH = itrs_pkg::NUMBER_WIDTH,
  parameter int MAX_SYMBOLS  = itrs_pkg::MAX_SYMBOLS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [itrs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [itrs_pkg::ALPHA_W-1:0]      cfg_data,
  input  logic signed [NUMBER_WIDTH-1:0]    in_number,
  input  logic                              out_stall,
  input  itrs_pkg::cmd_t                    cmd,
  output itrs_pkg::sts_t                    sts,
  output logic                              out_valid,
  output logic [itrs_pkg::SYM_W-1:0]        out_symbol,
  output logic                              out_last
);

  localparam int DIGIT_W   = $clog2(MAX_SYMBOLS);
  localparam int DIV_STEPS = (NUMBER_WIDTH + itrs_pkg::DIV_BITS - 1) / itrs_pkg::DIV_BITS;
  localparam int DIV_W     = DIV_STEPS * itrs_pkg::DIV_BITS;
  localparam int STEP_W    = $clog2(DIV_STEPS);
  localparam int CNT_W     = $clog2(NUMBER_WIDTH + 1);
  localparam int IDX_W     = $clog2(NUMBER_WIDTH);
  localparam int CMP_W     = itrs_pkg::RADIX_W + 1;

  logic [itrs_pkg::RADIX_W-1:0]  radix_r;
  logic [itrs_pkg::ALPHA_W-1:0]  alpha_lo_r;
  logic [itrs_pkg::ALPHA_W-1:0]  alpha_hi_r;

  logic [DIGIT_W-1:0]            chk_r;
  logic [DIV_W-1:0]              quo_r, quo_nxt;
  logic [DIGIT_W-1:0]            rem_r, rem_nxt;
  logic [STEP_W-1:0]             step_r;
  logic                          neg_r;
  logic [CNT_W-1:0]              cnt_r;
  logic [DIGIT_W-1:0]            stack_r [NUMBER_WIDTH];

  logic                          out_valid_r, out_valid_nxt;
  logic [itrs_pkg::SYM_W-1:0]    out_symbol_r;
  logic                          out_last_r;

  logic [NUMBER_WIDTH-1:0]       num_u;
  logic [NUMBER_WIDTH-1:0]       mag;
  logic [itrs_pkg::SYM_W-1:0]    sym_chk;
  logic                          dup;
  logic                          step_last;
  logic [CNT_W-1:0]              cnt_dec;
  logic [itrs_pkg::SYM_W-1:0]    sym_emit;
  logic                          emit_any;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r    <= '0;
      alpha_lo_r <= '0;
      alpha_hi_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        itrs_pkg::REG_RADIX:    radix_r    <= cfg_data[itrs_pkg::RADIX_W-1:0];
        itrs_pkg::REG_ALPHA_LO: alpha_lo_r <= cfg_data;
        itrs_pkg::REG_ALPHA_HI: alpha_hi_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign num_u = $unsigned(in_number);
  assign mag   = num_u[NUMBER_WIDTH-1] ? (~num_u + 1'b1) : num_u;

  // base check: one symbol per cycle against every later used symbol
  always_comb begin
    sym_chk = itrs_pkg::sym_at(alpha_lo_r, alpha_hi_r, itrs_pkg::SYM_IDX_W'(chk_r));
    dup     = 1'b0;
    for (int j = 0; j < MAX_SYMBOLS; j++) begin
      if ((itrs_pkg::RADIX_W'(j) > itrs_pkg::RADIX_W'(chk_r)) &&
          (itrs_pkg::RADIX_W'(j) < radix_r) &&
          (itrs_pkg::sym_at(alpha_lo_r, alpha_hi_r, itrs_pkg::SYM_IDX_W'(j)) == sym_chk)) begin
        dup = 1'b1;
      end
    end
  end

  // restoring division, DIV_BITS quotient bits per cycle
  always_comb begin
    logic [DIGIT_W-1:0] r;
    logic [DIV_W-1:0]   q;
    logic [CMP_W-1:0]   t;
    r = rem_r;
    q = quo_r;
    for (int k = 0; k < itrs_pkg::DIV_BITS; k++) begin
      t = CMP_W'({r, q[DIV_W-1]});
      q = {q[DIV_W-2:0], 1'b0};
      if (t >= CMP_W'(radix_r)) begin
        t    = t - CMP_W'(radix_r);
        q[0] = 1'b1;
      end
      r = t[DIGIT_W-1:0];
    end
    rem_nxt = r;
    quo_nxt = q;
  end

  assign step_last = (step_r == STEP_W'(DIV_STEPS - 1));
  assign cnt_dec   = cnt_r - 1'b1;
  assign sym_emit  = cmd.emit_minus ? itrs_pkg::SYM_MINUS :
                     itrs_pkg::sym_at(alpha_lo_r, alpha_hi_r,
                                      itrs_pkg::SYM_IDX_W'(stack_r[cnt_dec[IDX_W-1:0]]));
  assign emit_any  = cmd.emit_minus || cmd.emit_digit;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quo_r <= DIV_W'(mag);
      neg_r <= num_u[NUMBER_WIDTH-1];
      cnt_r <= '0;
      chk_r <= '0;
    end
    if (cmd.chk_next) begin
      chk_r <= chk_r + 1'b1;
    end
    if (cmd.div_init) begin
      rem_r  <= '0;
      step_r <= '0;
    end
    if (cmd.div_step) begin
      quo_r <= quo_nxt;
      if (step_last) begin
        stack_r[cnt_r[IDX_W-1:0]] <= rem_nxt;
        cnt_r  <= cnt_r + 1'b1;
        rem_r  <= '0;
        step_r <= '0;
      end else begin
        rem_r  <= rem_nxt;
        step_r <= step_r + 1'b1;
      end
    end
    if (emit_any) begin
      out_symbol_r <= sym_emit;
      out_last_r   <= cmd.emit_digit && (cnt_r == CNT_W'(1));
    end
    if (cmd.emit_digit) begin
      cnt_r <= cnt_dec;
    end
  end

  assign out_valid_nxt = emit_any || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    sts.radix_ok  = (radix_r >= itrs_pkg::RADIX_W'(2)) &&
                    (radix_r <= itrs_pkg::RADIX_W'(MAX_SYMBOLS));
    sts.sym_bad   = (sym_chk == itrs_pkg::SYM_NUL) || (sym_chk == itrs_pkg::SYM_PLUS) ||
                    (sym_chk == itrs_pkg::SYM_MINUS) || dup;
    sts.chk_last  = (itrs_pkg::RADIX_W'(chk_r) + itrs_pkg::RADIX_W'(1)) == radix_r;
    sts.div_last  = step_last;
    sts.quo_zero  = (quo_nxt == '0);
    sts.neg       = neg_r;
    sts.emit_last = (cnt_r == CNT_W'(1));
    sts.out_free  = !out_valid_r || !out_stall;
  end

  assign out_valid  = out_valid_r;
  assign out_symbol = out_symbol_r;
  assign out_last   = out_last_r;

endmodule

@@ rtl/core/integer_to_custom_radix_symbols.sv @@
// Top level of the integer to radix symbol block: controller plus datapath.
// Depends on itrs_pkg, itrs_ctrl and itrs_dp.
//
// Usage: write radix and the two alphabet words through the cfg_ port while
// the block is idle. Each item on the in_ channel is one signed number; the
// out_ channel returns its symbols most significant digit first, a leading
// minus for negative numbers, out_last on the final symbol. An invalid base
// consumes the item and returns nothing.
// Operation: one item is worked at a time. After acceptance the base check
// looks at each used symbol in turn (up to 16), then every digit is worked
// out by the 4-bit-per-cycle divider, then the symbols leave one at a time
// through the output register; the divider loop sets the rate.
// in_stall is low only while no item is in work.
// Reset clears the configuration registers to zero (base invalid) and
// empties the output. A stalled receiver holds the output register;
// emission waits, no symbol is lost.
module integer_to_custom_radix_symbols #(
  parameter int NUMBER_WIDTH = itrs_pkg::NUMBER_WIDTH,
  parameter int MAX_SYMBOLS  = itrs_pkg::MAX_SYMBOLS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [itrs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [itrs_pkg::ALPHA_W-1:0]    cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [NUMBER_WIDTH-1:0]  in_number,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [itrs_pkg::SYM_W-1:0]      out_symbol,
  output logic                            out_last
);

  itrs_pkg::cmd_t cmd;
  itrs_pkg::sts_t sts;

  itrs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  itrs_dp #(
    .NUMBER_WIDTH (NUMBER_WIDTH),
    .MAX_SYMBOLS  (MAX_SYMBOLS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_number  (in_number),
    .out_stall  (out_stall),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (out_valid),
    .out_symbol (out_symbol),
    .out_last   (out_last)
  );

endmodule

@@ rtl/core/itrs_checker.sv @@
// Port-level checks for the integer to radix symbol block, bound to the top.
// Depends on itrs_pkg for the symbol width.
module itrs_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [itrs_pkg::SYM_W-1:0] out_symbol,
  input logic                       out_last
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_reset_ready: assert property (@(posedge clk) !rst_n |=> !in_stall)
    else $error("input stalled after reset");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while one is in work");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_symbol) && $stable(out_last))
    else $error("stalled output changed");

endmodule

bind integer_to_custom_radix_symbols itrs_checker u_itrs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_symbol (out_symbol),
  .out_last   (out_last)
);

@@ test/integer_to_custom_radix_symbols_test.sv @@
// Testbench for integer_to_custom_radix_symbols: random and directed numbers
// checked symbol by symbol against a predictor of the radix rendering.
// Depends on itrs_pkg and the block's RTL.
module integer_to_custom_radix_symbols_test;
  timeunit 1ns;
  timeprecision 1ps;

  import itrs_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_BEYOND = 2'd3;
  localparam int SETTLE_CYCLES  = 320;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int ITEMS_PER_BASE = 40;
  localparam int PRINT_LIMIT    = 20;

  typedef struct {
    logic [SYM_W-1:0] symbol;
    logic             last;
  } rendered_symbol_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]        cfg_index = '0;
  logic [ALPHA_W-1:0]          cfg_data = '0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic signed [NUMBER_WIDTH-1:0] in_number = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [SYM_W-1:0]            out_symbol;
  logic                        out_last;

  logic [RADIX_W-1:0] radix_cfg = '0;
  logic [ALPHA_W-1:0] alpha_lo_cfg = '0;
  logic [ALPHA_W-1:0] alpha_hi_cfg = '0;

  rendered_symbol_t expected_symbols[$];
  int unsigned mismatches = 0;
  int unsigned numbers_sent = 0;
  int unsigned symbols_checked = 0;
  int unsigned bases_used = 0;
  int unsigned quiet_cycles = 0;
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  bit long_hold = 1'b0;

  integer_to_custom_radix_symbols uut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_number(in_number),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_symbol(out_symbol),
    .out_last(out_last)
  );

  always #4 clk = ~clk;

  function automatic logic [SYM_W-1:0] symbol_for(input int digit);
    return (digit < 8) ? alpha_lo_cfg[digit*8 +: 8] : alpha_hi_cfg[(digit-8)*8 +: 8];
  endfunction

  function automatic bit base_is_valid();
    logic [SYM_W-1:0] s;
    if (radix_cfg < 2 || radix_cfg > MAX_SYMBOLS) return 1'b0;
    for (int i = 0; i < radix_cfg; i++) begin
      s = symbol_for(i);
      if (s == SYM_NUL || s == SYM_PLUS || s == SYM_MINUS) return 1'b0;
      for (int j = i + 1; j < radix_cfg; j++)
        if (symbol_for(j) == s) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void predict_symbols(input logic signed [NUMBER_WIDTH-1:0] number);
    logic [NUMBER_WIDTH-1:0] magnitude;
    int digits[NUMBER_WIDTH];
    int count;
    rendered_symbol_t sym;
    if (!base_is_valid()) return;
    magnitude = number[NUMBER_WIDTH-1] ? (~number + 1'b1) : number;
    count = 0;
    do begin
      digits[count] = magnitude % radix_cfg;
      magnitude = magnitude / radix_cfg;
      count++;
    end while (magnitude != 0);
    if (number[NUMBER_WIDTH-1]) begin
      sym.symbol = SYM_MINUS;
      sym.last = 1'b0;
      expected_symbols.push_back(sym);
    end
    for (int k = count - 1; k >= 0; k--) begin
      sym.symbol = symbol_for(digits[k]);
      sym.last = (k == 0);
      expected_symbols.push_back(sym);
    end
  endfunction

  function automatic logic [NUMBER_WIDTH-1:0] random_number();
    longint unsigned power;
    logic [NUMBER_WIDTH-1:0] value;
    case ($urandom_range(0, 5))
      0: value = $urandom_range(0, 40) - 20;
      1: begin
        case ($urandom_range(0, 3))
          0: value = 32'h8000_0000;
          1: value = 32'h7FFF_FFFF;
          2: value = 32'h8000_0001;
          default: value = 32'hFFFF_FFFF;
        endcase
      end
      2: begin
        // land near a digit-count boundary of the current radix
        power = 1;
        repeat ($urandom_range(0, 31))
          if (radix_cfg >= 2 && power * radix_cfg <= 64'h8000_0000) power = power * radix_cfg;
        value = NUMBER_WIDTH'(power - $urandom_range(0, 1));
        if ($urandom_range(0, 1)) value = -value;
      end
      default: value = $urandom;
    endcase
    return value;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= PRINT_LIMIT) $display("ERROR %0t: %s", $realtime, what);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                input logic [ALPHA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    @(posedge clk);
    case (index)
      REG_RADIX: radix_cfg = data[RADIX_W-1:0];
      REG_ALPHA_LO: alpha_lo_cfg = data;
      REG_ALPHA_HI: alpha_hi_cfg = data;
      default: ;
    endcase
  endtask

  task automatic set_base(input logic [ALPHA_W-1:0] radix_word,
                          input logic [ALPHA_W-1:0] lo, input logic [ALPHA_W-1:0] hi);
    write_register(REG_RADIX, radix_word);
    write_register(REG_ALPHA_LO, lo);
    write_register(REG_ALPHA_HI, hi);
    cfg_we <= 1'b0;
    bases_used++;
  endtask

  task automatic make_alphabet(input int count, output logic [ALPHA_W-1:0] lo,
                               output logic [ALPHA_W-1:0] hi);
    logic [2*ALPHA_W-1:0] bytes;
    logic [SYM_W-1:0] pick;
    bit clash;
    bytes = {$urandom, $urandom, $urandom, $urandom};
    for (int i = 0; i < count; i++) begin
      do begin
        pick = SYM_W'($urandom_range(1, 255));
        clash = (pick == SYM_PLUS || pick == SYM_MINUS);
        for (int j = 0; j < i; j++)
          if (bytes[j*8 +: 8] == pick) clash = 1'b1;
      end while (clash);
      bytes[i*8 +: 8] = pick;
    end
    lo = bytes[ALPHA_W-1:0];
    hi = bytes[2*ALPHA_W-1:ALPHA_W];
  endtask

  task automatic send_number(input logic signed [NUMBER_WIDTH-1:0] value);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 15) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_number <= value;
    do @(posedge clk); while (in_stall);
    predict_symbols(value);
    numbers_sent++;
  endtask

  // drop valid, wait for every expected symbol, then let the block settle
  task automatic drain(input int settle);
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_symbols.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic test_reset_state();
    send_number(32'h0000_0000);
    send_number(32'h8000_0000);
    drain(SETTLE_CYCLES);
  endtask

  task automatic test_decimal();
    set_base(64'd10, 64'h3736_3534_3332_3130, 64'h0000_0000_0000_3938);
    send_number(32'h0000_0000);
    send_number(32'h0000_0007);
    send_number(32'hFFFF_FFFF);
    send_number(32'h0000_000A);
    send_number(32'h7FFF_FFFF);
    send_number(32'h8000_0000);
    send_number(32'hFFFF_FFF6);
    drain(SETTLE_CYCLES);
  endtask

  task automatic test_binary_extremes();
    logic [ALPHA_W-1:0] lo, hi;
    make_alphabet(2, lo, hi);
    set_base(64'd2, lo, hi);
    send_number(32'h8000_0000);
    send_number(32'h7FFF_FFFF);
    send_number(32'h5555_5555);
    send_number(32'hAAAA_AAAA);
    drain(SETTLE_CYCLES);
  endtask

  task automatic test_full_alphabet();
    // upper bits of the radix word are outside the register
    set_base(64'hFFFF_FFFF_FFFF_FFF0, 64'h3736_3534_3332_3130, 64'h4645_4443_4241_3938);
    send_number(32'h0123_4567);
    send_number(32'hFFFF_FFFF);
    drain(0);
    write_register(REG_BEYOND, 64'h2B2B_2B2B_2B2B_2B2B);
    cfg_we <= 1'b0;
    send_number(32'h89AB_CDEF);
    drain(SETTLE_CYCLES);
  endtask

  task automatic test_invalid_bases();
    logic [ALPHA_W-1:0] lo, hi;
    logic [2*ALPHA_W-1:0] word;
    logic [SYM_W-1:0] banned[3];
    int count, at, from;
    banned = '{SYM_NUL, SYM_PLUS, SYM_MINUS};
    make_alphabet(MAX_SYMBOLS, lo, hi);
    set_base(64'd1, lo, hi);
    send_number(random_number());
    drain(SETTLE_CYCLES);
    set_base(64'd17, lo, hi);
    send_number(random_number());
    drain(SETTLE_CYCLES);
    set_base(64'hFFFF_FFFF_FFFF_FFFF, lo, hi);
    send_number(random_number());
    drain(SETTLE_CYCLES);
    count = $urandom_range(2, MAX_SYMBOLS);
    make_alphabet(count, lo, hi);
    word = {hi, lo};
    at = $urandom_range(1, count - 1);
    from = $urandom_range(0, at - 1);
    word[at*8 +: 8] = word[from*8 +: 8];
    set_base(count, word[ALPHA_W-1:0], word[2*ALPHA_W-1:ALPHA_W]);
    send_number(random_number());
    drain(SETTLE_CYCLES);
    foreach (banned[b]) begin
      count = $urandom_range(2, MAX_SYMBOLS);
      make_alphabet(count, lo, hi);
      word = {hi, lo};
      at = $urandom_range(0, count - 1);
      word[at*8 +: 8] = banned[b];
      set_base(count, word[ALPHA_W-1:0], word[2*ALPHA_W-1:ALPHA_W]);
      send_number(random_number());
      drain(SETTLE_CYCLES);
    end
    // bytes above the radix are not checked
    set_base(64'd3, 64'h0061_2D2B_0063_6261, 64'h2B2D_0000_6161_2B2D);
    send_number(32'hFFFF_FF80);
    drain(SETTLE_CYCLES);
  endtask

  task automatic test_random_bases();
    logic [ALPHA_W-1:0] lo, hi, radix_word;
    int count;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: count = 2;
        1: count = MAX_SYMBOLS;
        default: count = $urandom_range(2, MAX_SYMBOLS);
      endcase
      tx_idle = (phase != 2);
      rx_idle = (phase != 3);
      make_alphabet(count, lo, hi);
      radix_word = ({$urandom, $urandom} & ~64'h1F) | count;
      set_base(radix_word, lo, hi);
      repeat (ITEMS_PER_BASE) send_number(random_number());
      drain(SETTLE_CYCLES);
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  task automatic test_output_hold();
    logic [ALPHA_W-1:0] lo, hi;
    make_alphabet(2, lo, hi);
    set_base(64'd2, lo, hi);
    tx_idle = 1'b0;
    long_hold = 1'b1;
    repeat (6) send_number(random_number());
    drain(SETTLE_CYCLES);
    tx_idle = 1'b1;
  endtask

  task automatic test_back_to_back();
    logic [ALPHA_W-1:0] lo, hi;
    int count;
    count = $urandom_range(2, MAX_SYMBOLS);
    make_alphabet(count, lo, hi);
    set_base(count, lo, hi);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    repeat (25) send_number(random_number());
    drain(0);
    rx_idle = 1'b1;
    repeat (25) send_number(random_number());
    drain(SETTLE_CYCLES);
    tx_idle = 1'b1;
  endtask

  initial begin : drive_receiver
    int unsigned wait_cycles;
    forever begin
      wait_cycles = rx_idle ? $urandom_range(0, 15) : 0;
      if (long_hold) begin
        wait_cycles = HOLD_CYCLES;
        long_hold = 1'b0;
      end
      if (wait_cycles != 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin : check_symbols
    rendered_symbol_t want;
    if (rst_n && out_valid && !out_stall) begin
      symbols_checked++;
      if (expected_symbols.size() == 0) begin
        report_mismatch($sformatf("unexpected symbol %h last %b", out_symbol, out_last));
      end else begin
        want = expected_symbols.pop_front();
        if (out_symbol !== want.symbol)
          report_mismatch($sformatf("symbol %h, expected %h", out_symbol, want.symbol));
        if (out_last !== want.last)
          report_mismatch($sformatf("last %b, expected %b on symbol %h",
                                    out_last, want.last, want.symbol));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", quiet_cycles);
      $display("integer_to_custom_radix_symbols: mismatch");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_decimal();
    test_binary_extremes();
    test_full_alphabet();
    test_invalid_bases();
    test_random_bases();
    test_output_hold();
    test_back_to_back();
    $display("rendered %0d numbers under %0d base settings, %0d symbols compared",
             numbers_sent, bases_used, symbols_checked);
    $display("covered invalid bases, radix 2 to 16, a long output stall and bursts");
    if (mismatches == 0) begin
      $display("integer_to_custom_radix_symbols: match");
    end else begin
      $display("integer_to_custom_radix_symbols: mismatch");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/itrs_pkg.sv
rtl/core/itrs_ctrl.sv
rtl/core/itrs_dp.sv
rtl/core/integer_to_custom_radix_symbols.sv
rtl/core/itrs_checker.sv
test/integer_to_custom_radix_symbols_test.sv
